// ===== rtl/apa_pkg.sv =====
// ----------------------------------------------------------------------------
// apa_pkg
// shared sizes, codes and types of the led string frame serializer
// ----------------------------------------------------------------------------
package apa_pkg;

  localparam int NUM_STRINGS     = 6;
  localparam int LEDS_PER_STRING = 32;
  localparam int TOTAL_LEDS      = NUM_STRINGS * LEDS_PER_STRING;

  localparam int ADDR_W = (TOTAL_LEDS > 1) ? $clog2(TOTAL_LEDS) : 1;
  localparam int IDX_W  = (LEDS_PER_STRING > 1) ? $clog2(LEDS_PER_STRING) : 1;
  localparam int STR_W  = 3;
  localparam int WORD_W = 32;

  // both queues have a power-of-two depth so the pointers wrap on their own
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // input command codes
  localparam logic [1:0] CMD_PLACE_POS = 2'd0;
  localparam logic [1:0] CMD_PLACE_IDX = 2'd1;
  localparam logic [1:0] CMD_EMIT      = 2'd2;

  localparam logic [7:0]        HDR_MARK   = 8'hE0;
  localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
  localparam logic [WORD_W-1:0] END_WORD   = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_WRITE,
    OP_EMIT
  } op_e;

  // classified command passed from front to back
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [STR_W-1:0]  str;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [STR_W-1:0]  str;
    logic [WORD_W-1:0] word;
    logic              last;
  } out_t;

endpackage

// ===== rtl/apa102_frame_buffer_serializer.sv =====
// ----------------------------------------------------------------------------
// apa102_frame_buffer_serializer
// frame store and word serializer for several strings of rgb leds
// ----------------------------------------------------------------------------
// input channel: an item is taken when push is high and full is low. pixel
//   items (place by continuous position, place by string and index) are
//   written into the frame store; an emit item sends one string's frame.
//   items with out-of-range fields or an unused command are taken and dropped
// result channel: while empty is low the oldest word sits on string_id_o,
//   frame_word_o and last_word_o; it is taken when pop is high
// front: classifies each item, builds the pixel word and the store address
// back: owns the frame store, one write or one read per cycle; it runs the
//   frame sequencer and feeds a four-entry result queue
// throughput: pixel items go at one per cycle while the back is idle; an emit
//   item holds the back through its dispatch, then the start word, one word per
//   led and the end word
// path: an emit item passes the command queue, the ST_START state and the s1
//   stage into the result queue before its start word shows on the result ports
// reset: the store reads as all zero through per-word written flags, so no
//   clearing sweep is needed and items are taken straight after reset
// receiver stall: the back stops issuing once the result queue is full,
//   commands then pile up in the four-entry queue and full rises
// ----------------------------------------------------------------------------
module apa102_frame_buffer_serializer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  position_i,
  input  logic [2:0]  string_sel_i,
  input  logic [5:0]  led_index_i,
  input  logic [4:0]  bright_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  // result item channel
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  string_id_o,
  output logic [31:0] frame_word_o,
  output logic        last_word_o
);
  import apa_pkg::*;

  // front to queue
  logic q_push;
  cmd_t q_cmd;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  out_t out_item;

  apa_front u_front (
    .push_i       (push),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .string_sel_i (string_sel_i),
    .led_index_i  (led_index_i),
    .bright_i     (bright_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd)
  );

  // decouples item intake from frame streaming
  apa_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  apa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .out_item_o  (out_item)
  );

  // dropped items never reach the queue, so full alone gates intake
  assign full         = q_full;
  assign string_id_o  = out_item.str;
  assign frame_word_o = out_item.word;
  assign last_word_o  = out_item.last;

endmodule

// ===== rtl/apa_front.sv =====
// ----------------------------------------------------------------------------
// apa_front
// classifies input items, builds pixel words and store addresses
// ----------------------------------------------------------------------------
module apa_front (
  input  logic               push_i,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         position_i,
  input  logic [2:0]         string_sel_i,
  input  logic [5:0]         led_index_i,
  input  logic [4:0]         bright_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output apa_pkg::cmd_t      q_cmd_o
);
  import apa_pkg::*;

  logic keep;

  always_comb begin
    keep          = 1'b0;
    q_cmd_o.op    = OP_WRITE;
    q_cmd_o.addr  = '0;
    q_cmd_o.str   = string_sel_i;
    q_cmd_o.word  = {HDR_MARK | {3'b000, bright_i}, blue_i, green_i, red_i};
    unique case (cmd_i)
      CMD_PLACE_POS: begin
        keep         = 32'(position_i) < 32'(TOTAL_LEDS);
        q_cmd_o.addr = ADDR_W'(position_i);
      end
      CMD_PLACE_IDX: begin
        keep         = (32'(string_sel_i) < 32'(NUM_STRINGS)) &&
                       (32'(led_index_i) < 32'(LEDS_PER_STRING));
        q_cmd_o.addr = ADDR_W'(32'(string_sel_i) * LEDS_PER_STRING + 32'(led_index_i));
      end
      CMD_EMIT: begin
        keep         = 32'(string_sel_i) < 32'(NUM_STRINGS);
        q_cmd_o.op   = OP_EMIT;
        q_cmd_o.addr = ADDR_W'(32'(string_sel_i) * LEDS_PER_STRING);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // items that do nothing are taken but never queued
  assign q_push_o = push_i && keep && !q_full_i;

endmodule

// ===== rtl/apa_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// apa_cmd_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module apa_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  apa_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output apa_pkg::cmd_t head_o
);
  import apa_pkg::*;

  cmd_t                  slot_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= cmd_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue count past depth");

endmodule

// ===== rtl/apa_back.sv =====
// ----------------------------------------------------------------------------
// apa_back
// frame store, frame sequencer and result queue
// ----------------------------------------------------------------------------
module apa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  apa_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  input  logic          out_pop_i,
  output logic          out_empty_o,
  output apa_pkg::out_t out_item_o
);
  import apa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BODY,
    ST_END
  } state_e;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_END
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [STR_W-1:0] str;
  } stage_t;

  state_e            state_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ADDR_W-1:0] base_q;
  logic [STR_W-1:0]  str_q;
  stage_t            s1_q;

  logic [WORD_W-1:0]     mem_q [TOTAL_LEDS];
  logic [TOTAL_LEDS-1:0] vld_q;
  logic [WORD_W-1:0]     rdata_q;
  logic                  rvld_q;

  out_t                  outq_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] out_wr_q, out_rd_q;
  logic [OUTQ_CNT_W-1:0] out_cnt_q;

  logic              can_issue;
  logic              mem_we;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_push, out_pop;
  out_t              out_new;

  // room for one more word, counting the one in flight
  assign can_issue = ({1'b0, out_cnt_q} + {{OUTQ_CNT_W{1'b0}}, s1_q.valid})
                     < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign mem_we  = q_pop_o && (q_head_i.op == OP_WRITE);
  assign rd_en   = (state_q == ST_BODY) && can_issue;
  assign rd_addr = base_q + ADDR_W'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      base_q  <= '0;
      str_q   <= '0;
      s1_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          s1_q.valid <= 1'b0;
          if (q_pop_o && q_head_i.op == OP_EMIT) begin
            base_q  <= q_head_i.addr;
            str_q   <= q_head_i.str;
            state_q <= ST_START;
          end
        end
        ST_START: begin
          if (can_issue) begin
            s1_q    <= '{valid: 1'b1, kind: KIND_START, str: str_q};
            idx_q   <= '0;
            state_q <= ST_BODY;
          end else begin
            s1_q.valid <= 1'b0;
          end
        end
        ST_BODY: begin
          if (can_issue) begin
            s1_q <= '{valid: 1'b1, kind: KIND_DATA, str: str_q};
            if (idx_q == IDX_W'(LEDS_PER_STRING - 1)) state_q <= ST_END;
            else idx_q <= idx_q + 1'b1;
          end else begin
            s1_q.valid <= 1'b0;
          end
        end
        ST_END: begin
          if (can_issue) begin
            s1_q    <= '{valid: 1'b1, kind: KIND_END, str: str_q};
            state_q <= ST_IDLE;
          end else begin
            s1_q.valid <= 1'b0;
          end
        end
        default: begin
          s1_q.valid <= 1'b0;
          state_q    <= ST_IDLE;
        end
      endcase
    end
  end

  // written-once flags stand in for clearing the store at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[q_head_i.addr] <= 1'b1;
      if (rd_en)  rvld_q <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[q_head_i.addr] <= q_head_i.word;
    if (rd_en)  rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    out_new.str  = s1_q.str;
    out_new.last = s1_q.kind == KIND_END;
    unique case (s1_q.kind)
      KIND_START: out_new.word = START_WORD;
      KIND_DATA:  out_new.word = rvld_q ? rdata_q : '0;
      KIND_END:   out_new.word = END_WORD;
      default:    out_new.word = START_WORD;
    endcase
  end

  assign out_push    = s1_q.valid;
  assign out_empty_o = out_cnt_q == '0;
  assign out_pop     = out_pop_i && !out_empty_o;
  assign out_item_o  = outq_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (out_push) out_wr_q <= out_wr_q + 1'b1;
      if (out_pop)  out_rd_q <= out_rd_q + 1'b1;
      if (out_push && !out_pop)      out_cnt_q <= out_cnt_q + 1'b1;
      else if (out_pop && !out_push) out_cnt_q <= out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) outq_q[out_wr_q] <= out_new;
  end

  a_outq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_push && out_cnt_q == OUTQ_CNT_W'(OUTQ_DEPTH)))
    else $error("result queue written while full");

  a_end_word_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_END && can_issue) |=> (s1_q.valid && s1_q.kind == KIND_END))
    else $error("end of frame word not issued");

  a_no_write_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !(s1_q.valid && s1_q.kind == KIND_DATA))
    else $error("store written while a frame is being read");

endmodule

// ===== tb/apa102_frame_buffer_serializer_tb.sv =====
// ----------------------------------------------------------------------------
// apa102_frame_buffer_serializer_tb
// self-checking bench for the led string frame store and word serializer
// ----------------------------------------------------------------------------
// a queue of pending items is filled up front: a short directed list for the
// corner cases, then random pixel writes, emits and ignored items. a clocked
// driver hands them to the block and updates a local copy of the frame store
// at each accepted item, queueing the words that an emit must produce. a
// clocked monitor pops results and compares each one with the oldest queued
// word. both sides idle at random in three phases, the last with no idling.
// ----------------------------------------------------------------------------
module apa102_frame_buffer_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apa_pkg::*;

  // the spare command code, taken and dropped by the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int N_RANDOM = 250;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] position;
    logic [2:0] sel;
    logic [5:0] idx;
    logic [4:0] bright;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         drain_first;  // hold this item back until all words are out
  } led_cmd_t;

  typedef struct {
    logic [2:0]  str;
    logic [31:0] word;
    logic        last;
  } frame_out_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [1:0]  cmd_i        = '0;
  logic [7:0]  position_i   = '0;
  logic [2:0]  string_sel_i = '0;
  logic [5:0]  led_index_i  = '0;
  logic [4:0]  bright_i     = '0;
  logic [7:0]  red_i        = '0;
  logic [7:0]  green_i      = '0;
  logic [7:0]  blue_i       = '0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [2:0]  string_id_o;
  logic [31:0] frame_word_o;
  logic        last_word_o;

  led_cmd_t    cmd_backlog[$];   // items still to be offered
  frame_out_t  pending_words[$]; // words the block still owes
  logic [31:0] led_words[TOTAL_LEDS];
  led_cmd_t    on_port;          // item currently offered on the ports
  int          n_items = 0;
  int          n_issued = 0;
  int          mismatches = 0;
  int          idle_phase = 0;   // 0, 1: mixed idling; 2: no idling

  apa102_frame_buffer_serializer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .string_sel_i (string_sel_i),
    .led_index_i  (led_index_i),
    .bright_i     (bright_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .empty        (empty),
    .pop          (pop),
    .string_id_o  (string_id_o),
    .frame_word_o (frame_word_o),
    .last_word_o  (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver idles more in the first phase, sender in the second
  function automatic int unsigned sender_idle_pct(int ph);
    return (ph == 0) ? 34 : (ph == 1) ? 78 : 0;
  endfunction

  function automatic int unsigned receiver_idle_pct(int ph);
    return (ph == 0) ? 78 : (ph == 1) ? 34 : 0;
  endfunction

  function automatic led_cmd_t mk_item(logic [1:0] cmd, logic [7:0] pos, logic [2:0] sel,
                                       logic [5:0] idx, logic [4:0] bright,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
    led_cmd_t it;
    it.cmd = cmd;
    it.position = pos;
    it.sel = sel;
    it.idx = idx;
    it.bright = bright;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.drain_first = 1'b0;
    return it;
  endfunction

  // mostly in-range fields, with a tail that reaches the ignored values
  function automatic led_cmd_t rand_item();
    led_cmd_t    it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    it = mk_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    if (roll < 40) begin
      it.cmd = CMD_PLACE_POS;
      if ($urandom_range(0, 9) != 0) it.position = 8'($urandom_range(0, TOTAL_LEDS - 1));
    end else if (roll < 70) begin
      it.cmd = CMD_PLACE_IDX;
      if ($urandom_range(0, 9) != 0) it.sel = 3'($urandom_range(0, NUM_STRINGS - 1));
      if ($urandom_range(0, 9) != 0) it.idx = 6'($urandom_range(0, LEDS_PER_STRING - 1));
    end else if (roll < 92) begin
      it.cmd = CMD_EMIT;
      if ($urandom_range(0, 7) != 0) it.sel = 3'($urandom_range(0, NUM_STRINGS - 1));
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // local frame store update and word prediction for one accepted item
  task automatic apply_led_cmd(input led_cmd_t it);
    logic [31:0] pix;
    pix = {HDR_MARK | {3'b000, it.bright}, it.blue, it.green, it.red};
    case (it.cmd)
      CMD_PLACE_POS: begin
        // position splits exactly into string and index, so it is the address
        if (it.position < TOTAL_LEDS) led_words[it.position] = pix;
      end
      CMD_PLACE_IDX: begin
        if (it.sel < NUM_STRINGS && it.idx < LEDS_PER_STRING)
          led_words[it.sel * LEDS_PER_STRING + it.idx] = pix;
      end
      CMD_EMIT: begin
        if (it.sel < NUM_STRINGS) begin
          pending_words.push_back('{str: it.sel, word: START_WORD, last: 1'b0});
          for (int i = 0; i < LEDS_PER_STRING; i++)
            pending_words.push_back('{str: it.sel,
                                      word: led_words[it.sel * LEDS_PER_STRING + i],
                                      last: 1'b0});
          pending_words.push_back('{str: it.sel, word: END_WORD, last: 1'b1});
        end
      end
      default: begin
        // unused command: no effect
      end
    endcase
  endtask

  // driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) apply_led_cmd(on_port);
      if (!push || !full) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct(idle_phase)
            && !(cmd_backlog[0].drain_first && pending_words.size() != 0)) begin
          on_port      = cmd_backlog.pop_front();
          n_issued     = n_issued + 1;
          cmd_i        <= on_port.cmd;
          position_i   <= on_port.position;
          string_sel_i <= on_port.sel;
          led_index_i  <= on_port.idx;
          bright_i     <= on_port.bright;
          red_i        <= on_port.red;
          green_i      <= on_port.green;
          blue_i       <= on_port.blue;
          push         <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      idle_phase <= (n_items == 0) ? 0 : (n_issued * 3) / n_items;
    end
  end

  // monitor: check each popped word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    frame_out_t exp_w;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: string_id %0d frame_word %08h last_word %0b",
                 string_id_o, frame_word_o, last_word_o);
          mismatches = mismatches + 1;
        end else begin
          exp_w = pending_words.pop_front();
          if (string_id_o !== exp_w.str) begin
            $error("string_id: expected %0d, got %0d", exp_w.str, string_id_o);
            mismatches = mismatches + 1;
          end
          if (frame_word_o !== exp_w.word) begin
            $error("frame_word: expected %08h, got %08h", exp_w.word, frame_word_o);
            mismatches = mismatches + 1;
          end
          if (last_word_o !== exp_w.last) begin
            $error("last_word: expected %0b, got %0b", exp_w.last, last_word_o);
            mismatches = mismatches + 1;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= receiver_idle_pct(idle_phase));
    end
  end

  // stimulus, reset and end of run
  initial begin
    led_cmd_t it;
    for (int i = 0; i < TOTAL_LEDS; i++) led_words[i] = '0;

    // directed: field extremes, ignored positions, strings and indexes
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd0, 3'd0, 6'd0, 5'd31,
                                  8'hFF, 8'hFF, 8'hFF));
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd31, 3'd7, 6'd63, 5'd0,
                                  8'h00, 8'h00, 8'h00));
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd191, 3'd0, 6'd0, 5'd5,
                                  8'hA5, 8'h5A, 8'h3C));
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd32, 3'd0, 6'd0, 5'd9,
                                  8'h12, 8'h34, 8'h56));
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd63, 3'd0, 6'd0, 5'd30,
                                  8'h81, 8'h42, 8'h24));
    // past the last led: dropped
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd192, 3'd0, 6'd0, 5'd1,
                                  8'h11, 8'h22, 8'h33));
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd255, 3'd0, 6'd0, 5'd2,
                                  8'h44, 8'h55, 8'h66));
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd0, 3'd0, 6'd1, 5'd17,
                                  8'h01, 8'h80, 8'h7F));
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd255, 3'd5, 6'd31, 5'd31,
                                  8'hFE, 8'hDC, 8'hBA));
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd0, 3'd5, 6'd0, 5'd0,
                                  8'h0F, 8'hF0, 8'hAA));
    // string past the last one, index past the string end: dropped
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd0, 3'd6, 6'd3, 5'd7,
                                  8'h99, 8'h99, 8'h99));
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd0, 3'd7, 6'd63, 5'd7,
                                  8'h98, 8'h97, 8'h96));
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd0, 3'd2, 6'd32, 5'd7,
                                  8'h95, 8'h94, 8'h93));
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd0, 3'd2, 6'd63, 5'd7,
                                  8'h92, 8'h91, 8'h90));
    cmd_backlog.push_back(mk_item(CMD_UNUSED, 8'd255, 3'd7, 6'd63, 5'd31,
                                  8'hFF, 8'hFF, 8'hFF));
    cmd_backlog.push_back(mk_item(CMD_EMIT, 8'd0, 3'd0, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00));
    cmd_backlog.push_back(mk_item(CMD_EMIT, 8'd0, 3'd1, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00));
    cmd_backlog.push_back(mk_item(CMD_EMIT, 8'd0, 3'd5, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00));
    // emits of strings that do not exist give no words
    cmd_backlog.push_back(mk_item(CMD_EMIT, 8'd0, 3'd6, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00));
    cmd_backlog.push_back(mk_item(CMD_EMIT, 8'd0, 3'd7, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00));
    // untouched string: all zero pixel words
    cmd_backlog.push_back(mk_item(CMD_EMIT, 8'd0, 3'd3, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00));
    // write straight after an emit must not leak into it, then string 0 is emitted once drained
    cmd_backlog.push_back(mk_item(CMD_PLACE_POS, 8'd0, 3'd0, 6'd0, 5'd12,
                                  8'h3C, 8'hC3, 8'h66));
    it = mk_item(CMD_EMIT, 8'd0, 3'd0, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00);
    it.drain_first = 1'b1;
    cmd_backlog.push_back(it);
    // write then emit back to back
    cmd_backlog.push_back(mk_item(CMD_PLACE_IDX, 8'd0, 3'd3, 6'd10, 5'd21,
                                  8'h5A, 8'hA5, 8'hC0));
    cmd_backlog.push_back(mk_item(CMD_EMIT, 8'd0, 3'd3, 6'd0, 5'd0, 8'h00, 8'h00, 8'h00));

    for (int i = 0; i < N_RANDOM; i++) begin
      it = rand_item();
      // one hold-off midway: wait for the result side to run dry
      if (i == N_RANDOM / 2) it.drain_first = 1'b1;
      cmd_backlog.push_back(it);
    end
    n_items = cmd_backlog.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all items taken, then all words out, then a quiet spell for strays
    while (cmd_backlog.size() != 0 || push) @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (LEDS_PER_STRING + 16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("apa102_frame_buffer_serializer_tb passed");
    end else begin
      $display("apa102_frame_buffer_serializer_tb failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("apa102_frame_buffer_serializer_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/apa_pkg.sv
rtl/apa_front.sv
rtl/apa_cmd_queue.sv
rtl/apa_back.sv
rtl/apa102_frame_buffer_serializer.sv
tb/apa102_frame_buffer_serializer_tb.sv
